// ===== src/lkvc_pkg.sv =====
// lkvc_pkg: shared types for the lru key-value cache with ttl expiry
// depends on nothing; used by the top level and the bench
`timescale 1ns / 1ps
package lkvc_pkg;

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_EXISTS = 3'd3,
    CMD_TICK   = 3'd4
  } lkvc_cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PASS,
    ST_RESP
  } lkvc_state_e;

  localparam int unsigned TimeBits = 40;
  localparam int unsigned TtlBits  = 16;
  localparam int unsigned CapBits  = 7;
  localparam logic [CapBits-1:0] CapReset = 7'd64;

endpackage

// ===== src/lru_key_value_cache_ttl.sv =====
// lru_key_value_cache_ttl: fully associative key-value table, lru replacement, ttl expiry
// depends on lkvc_pkg (types, constants) and lkvc_ram (entry store)
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  s_axis   | in  | tvalid / tready      | tuser: command; tdata: key, value, has_ttl,
//           |     |                      |   ttl_seconds
//  m_axis   | out | tvalid / tready      | tuser: found; tdata: read_value
//  cfg      | in  | valid / ready        | data: capacity
//
//  every entry lives in one ram word (valid, key, value, ttl flag, expiry, age rank)
//  a get, set, remove or exists request first scans the whole ram for the key, the oldest
//  entry and a free slot, then passes through a decide state; a request that changes recency
//  or drops an entry then makes a read-modify-write pass over the ram before its result;
//  a tick or an unused command skips the scan and goes straight to the result state
//  one request is in work at a time
//  after reset a clearing pass empties the ram before s_axis is ready
//  the result waits in an output register, so a stalled m_axis holds only the next result
`timescale 1ns / 1ps
module lru_key_value_cache_ttl #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command request
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [151:0] s_axis_tdata_i,  // key[63:0], value[127:64], has_ttl[128],
                                        // ttl_seconds[144:129], zero[151:145]
  input  logic [2:0]   s_axis_tuser_i,  // command[2:0]
  // result
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,  // read_value[63:0]
  output logic         m_axis_tuser_o,  // found[0]
  // capacity register
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [6:0]   cfg_data_i
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned LW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (LW > lkvc_pkg::CapBits) ? LW : lkvc_pkg::CapBits;
  localparam int unsigned TW   = lkvc_pkg::TimeBits;

  // one ram word per entry
  typedef struct packed {
    logic                  valid;
    logic [AW-1:0]         rank;
    logic [TW-1:0]         expiry;
    logic                  has_ttl;
    logic [VALUE_BITS-1:0] value;
    logic [KEY_BITS-1:0]   key;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  lkvc_pkg::lkvc_state_e state_q, state_d;

  logic [LW-1:0] cnt_q, cnt_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  // request payload
  logic [2:0]                  cmd_q;
  logic [KEY_BITS-1:0]         key_q;
  logic [VALUE_BITS-1:0]       val_q;
  logic                        ttl_q;
  logic [lkvc_pkg::TtlBits-1:0] secs_q;

  // scan results
  logic                  hit_q, hit_d;
  logic [AW-1:0]         hidx_q, hidx_d;
  logic [VALUE_BITS-1:0] hval_q, hval_d;
  logic                  httl_q, httl_d;
  logic [TW-1:0]         hexp_q, hexp_d;
  logic [AW-1:0]         hrank_q, hrank_d;
  logic                  old_fnd_q, old_fnd_d;
  logic [AW-1:0]         old_idx_q, old_idx_d;
  logic [AW-1:0]         old_rank_q, old_rank_d;
  logic                  free_fnd_q, free_fnd_d;
  logic [AW-1:0]         free_idx_q, free_idx_d;

  // write-back pass controls
  logic          drop_en_q, drop_en_d;
  logic [AW-1:0] drop_idx_q, drop_idx_d;
  logic [AW-1:0] drop_r_q, drop_r_d;
  logic          rec_en_q, rec_en_d;
  logic [AW-1:0] rec_idx_q, rec_idx_d;
  logic [LW-1:0] rec_r_q, rec_r_d;
  logic          wr_q, wr_d;
  logic [TW-1:0] exp_q, exp_d;

  logic                  found_q, found_d;
  logic [VALUE_BITS-1:0] rv_q, rv_d;
  logic [LW-1:0]         live_q, live_d;
  logic [TW-1:0]         now_q, now_d;
  logic [lkvc_pkg::CapBits-1:0] cap_q;

  logic        out_vq, out_vd;
  logic        out_found_q, out_found_d;
  logic [63:0] out_val_q, out_val_d;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  entry_t        ram_wd;
  logic [AW-1:0] ram_ra;
  logic [EW-1:0] ram_rd;
  entry_t        rw;
  entry_t        nw;

  logic            s_acc;
  logic            issue;
  logic [CMPW-1:0] cap_eff;
  logic            expired;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign rw    = entry_t'(ram_rd);
  assign issue = cnt_q < LW'(TABLE_DEPTH);

  assign expired = httl_q && (now_q >= hexp_q);

  // capacity 0 acts as 1, above the table depth acts as the depth
  always_comb begin
    cap_eff = CMPW'(cap_q);
    if (cap_eff == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_eff > CMPW'(TABLE_DEPTH)) begin
      cap_eff = CMPW'(TABLE_DEPTH);
    end
  end

  lkvc_ram #(
    .Width (EW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  // modified word for the write-back pass: drop first, then make recent
  always_comb begin
    nw = rw;
    if (drop_en_q) begin
      if (rd_idx_q == drop_idx_q) begin
        nw.valid = 1'b0;
      end else if (rw.valid && (rw.rank > drop_r_q)) begin
        nw.rank = rw.rank - AW'(1);
      end
    end
    if (rec_en_q) begin
      if (rd_idx_q == rec_idx_q) begin
        nw.rank = '0;
        if (wr_q) begin
          nw.valid   = 1'b1;
          nw.key     = key_q;
          nw.value   = val_q;
          nw.has_ttl = ttl_q;
          if (ttl_q) begin
            nw.expiry = exp_q;
          end
        end
      end else if (nw.valid && (LW'(nw.rank) < rec_r_q)) begin
        nw.rank = nw.rank + AW'(1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    hval_d      = hval_q;
    httl_d      = httl_q;
    hexp_d      = hexp_q;
    hrank_d     = hrank_q;
    old_fnd_d   = old_fnd_q;
    old_idx_d   = old_idx_q;
    old_rank_d  = old_rank_q;
    free_fnd_d  = free_fnd_q;
    free_idx_d  = free_idx_q;
    drop_en_d   = drop_en_q;
    drop_idx_d  = drop_idx_q;
    drop_r_d    = drop_r_q;
    rec_en_d    = rec_en_q;
    rec_idx_d   = rec_idx_q;
    rec_r_d     = rec_r_q;
    wr_d        = wr_q;
    exp_d       = exp_q;
    found_d     = found_q;
    rv_d        = rv_q;
    live_d      = live_q;
    now_d       = now_q;
    out_vd      = out_vq;
    out_found_d = out_found_q;
    out_val_d   = out_val_q;
    ram_we      = 1'b0;
    ram_wa      = rd_idx_q;
    ram_wd      = nw;
    ram_ra      = cnt_q[AW-1:0];
    s_axis_tready_o = 1'b0;

    if (out_vq && m_axis_tready_i) begin
      out_vd = 1'b0;
    end

    case (state_q)
      lkvc_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = cnt_q[AW-1:0];
        ram_wd = '0;
        cnt_d  = cnt_q + LW'(1);
        if (cnt_q == LW'(TABLE_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = lkvc_pkg::ST_IDLE;
        end
      end

      lkvc_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_acc) begin
          found_d    = 1'b0;
          rv_d       = '0;
          hit_d      = 1'b0;
          old_fnd_d  = 1'b0;
          free_fnd_d = 1'b0;
          drop_en_d  = 1'b0;
          rec_en_d   = 1'b0;
          wr_d       = 1'b0;
          cnt_d      = '0;
          case (s_axis_tuser_i)
            lkvc_pkg::CMD_GET, lkvc_pkg::CMD_SET,
            lkvc_pkg::CMD_REMOVE, lkvc_pkg::CMD_EXISTS: begin
              state_d = lkvc_pkg::ST_SCAN;
            end
            lkvc_pkg::CMD_TICK: begin
              now_d   = now_q + TW'(1);
              state_d = lkvc_pkg::ST_RESP;
            end
            default: begin
              state_d = lkvc_pkg::ST_RESP;
            end
          endcase
        end
      end

      lkvc_pkg::ST_SCAN: begin
        if (issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[AW-1:0];
          cnt_d    = cnt_q + LW'(1);
        end
        if (rd_vld_q) begin
          // first match, oldest live entry, first free slot
          if (rw.valid && (rw.key == key_q) && !hit_q) begin
            hit_d   = 1'b1;
            hidx_d  = rd_idx_q;
            hval_d  = rw.value;
            httl_d  = rw.has_ttl;
            hexp_d  = rw.expiry;
            hrank_d = rw.rank;
          end
          if (rw.valid && (!old_fnd_q || (rw.rank > old_rank_q))) begin
            old_fnd_d  = 1'b1;
            old_idx_d  = rd_idx_q;
            old_rank_d = rw.rank;
          end
          if (!rw.valid && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
        if (!issue && !rd_vld_q) begin
          cnt_d   = '0;
          state_d = lkvc_pkg::ST_DECIDE;
        end
      end

      lkvc_pkg::ST_DECIDE: begin
        state_d = lkvc_pkg::ST_RESP;
        case (cmd_q)
          lkvc_pkg::CMD_GET, lkvc_pkg::CMD_EXISTS: begin
            if (hit_q) begin
              if (expired) begin
                drop_en_d  = 1'b1;
                drop_idx_d = hidx_q;
                drop_r_d   = hrank_q;
                live_d     = live_q - LW'(1);
                state_d    = lkvc_pkg::ST_PASS;
              end else begin
                found_d = 1'b1;
                if (cmd_q == lkvc_pkg::CMD_GET) begin
                  rv_d      = hval_q;
                  rec_en_d  = 1'b1;
                  rec_idx_d = hidx_q;
                  rec_r_d   = LW'(hrank_q);
                  state_d   = lkvc_pkg::ST_PASS;
                end
              end
            end
          end
          lkvc_pkg::CMD_SET: begin
            wr_d     = 1'b1;
            rec_en_d = 1'b1;
            exp_d    = now_q + TW'(secs_q);
            state_d  = lkvc_pkg::ST_PASS;
            if (hit_q) begin
              found_d   = 1'b1;
              rec_idx_d = hidx_q;
              rec_r_d   = LW'(hrank_q);
            end else if (CMPW'(live_q) >= cap_eff) begin
              // evict the oldest, the new key takes the lowest free slot after that
              drop_en_d  = 1'b1;
              drop_idx_d = old_idx_q;
              drop_r_d   = old_rank_q;
              rec_r_d    = live_q - LW'(1);
              rec_idx_d  = (free_fnd_q && (free_idx_q < old_idx_q)) ? free_idx_q : old_idx_q;
            end else begin
              rec_idx_d = free_idx_q;
              rec_r_d   = live_q;
              live_d    = live_q + LW'(1);
            end
          end
          lkvc_pkg::CMD_REMOVE: begin
            if (hit_q) begin
              found_d    = 1'b1;
              drop_en_d  = 1'b1;
              drop_idx_d = hidx_q;
              drop_r_d   = hrank_q;
              live_d     = live_q - LW'(1);
              state_d    = lkvc_pkg::ST_PASS;
            end
          end
          default: begin
            state_d = lkvc_pkg::ST_RESP;
          end
        endcase
      end

      lkvc_pkg::ST_PASS: begin
        if (issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[AW-1:0];
          cnt_d    = cnt_q + LW'(1);
        end
        ram_we = rd_vld_q;
        if (!issue && !rd_vld_q) begin
          cnt_d   = '0;
          state_d = lkvc_pkg::ST_RESP;
        end
      end

      lkvc_pkg::ST_RESP: begin
        if (!out_vq || m_axis_tready_i) begin
          out_vd      = 1'b1;
          out_found_d = found_q;
          out_val_d   = 64'(rv_q);
          state_d     = lkvc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lkvc_pkg::ST_CLEAR;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      old_fnd_q  <= 1'b0;
      free_fnd_q <= 1'b0;
      drop_en_q  <= 1'b0;
      rec_en_q   <= 1'b0;
      wr_q       <= 1'b0;
      live_q     <= '0;
      now_q      <= '0;
      cap_q      <= lkvc_pkg::CapReset;
      out_vq     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      hit_q      <= hit_d;
      old_fnd_q  <= old_fnd_d;
      free_fnd_q <= free_fnd_d;
      drop_en_q  <= drop_en_d;
      rec_en_q   <= rec_en_d;
      wr_q       <= wr_d;
      live_q     <= live_d;
      now_q      <= now_d;
      out_vq     <= out_vd;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q  <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i[KEY_BITS-1:0];
      val_q  <= s_axis_tdata_i[64 +: VALUE_BITS];
      ttl_q  <= s_axis_tdata_i[128];
      secs_q <= s_axis_tdata_i[144:129];
    end
    rd_idx_q    <= rd_idx_d;
    hidx_q      <= hidx_d;
    hval_q      <= hval_d;
    httl_q      <= httl_d;
    hexp_q      <= hexp_d;
    hrank_q     <= hrank_d;
    old_idx_q   <= old_idx_d;
    old_rank_q  <= old_rank_d;
    free_idx_q  <= free_idx_d;
    drop_idx_q  <= drop_idx_d;
    drop_r_q    <= drop_r_d;
    rec_idx_q   <= rec_idx_d;
    rec_r_q     <= rec_r_d;
    exp_q       <= exp_d;
    found_q     <= found_d;
    rv_q        <= rv_d;
    out_found_q <= out_found_d;
    out_val_q   <= out_val_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_found_q;

endmodule

// ===== src/lkvc_ram.sv =====
// lkvc_ram: simple dual-port synchronous ram, one write and one read port
// read data is registered; no package dependency
`timescale 1ns / 1ps
module lkvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lkvc_checker.sv =====
// lkvc_checker: port-level assertions for the lru key-value cache
// depends on nothing but the top level's ports; bound to lru_key_value_cache_ttl below
`timescale 1ns / 1ps
module lkvc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // a value is only returned on a hit
  a_value_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o != 64'd0) |-> m_axis_tuser_o)
    else $error("value returned without found");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in work");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result shown after reset");

endmodule

bind lru_key_value_cache_ttl lkvc_checker u_lkvc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for lru_key_value_cache_ttl, streams commands and checks results
// depends on lkvc_pkg and the top level; keeps its own model of the cache table
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned Depth = 64;
  localparam longint unsigned CycleLimit = 64'd2_000_000;
  localparam logic [39:0] TimeMask = 40'hff_ffff_ffff;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [151:0] s_axis_tdata_i = '0;  // key, value, has_ttl, ttl_seconds, zero pad
  logic [2:0]   s_axis_tuser_i = '0;  // command
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;       // read_value
  logic         m_axis_tuser_o;       // found
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [6:0]   cfg_data_i = '0;

  lru_key_value_cache_ttl dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // model of the cache table
  logic        mdl_valid [Depth];
  logic [63:0] mdl_key   [Depth];
  logic [63:0] mdl_value [Depth];
  logic        mdl_ttl   [Depth];
  logic [39:0] mdl_expiry[Depth];
  int unsigned mdl_rank  [Depth];
  int unsigned mdl_live;
  logic [39:0] mdl_now;
  logic [6:0]  mdl_capacity;

  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
  } lookup_result_t;

  lookup_result_t pending_results[$];
  int  error_count = 0;
  bit  quiet_mode = 1'b0;  // disables random idling for a long stretch
  longint unsigned cycle_count = 0;

  function automatic int find_slot(logic [63:0] k);
    for (int i = 0; i < Depth; i++)
      if (mdl_valid[i] && mdl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int idx);
    int unsigned r;
    r = mdl_rank[idx];
    mdl_valid[idx] = 1'b0;
    for (int i = 0; i < Depth; i++)
      if (mdl_valid[i] && mdl_rank[i] > r) mdl_rank[i]--;
    if (mdl_live > 0) mdl_live--;
  endfunction

  function automatic void touch_slot(int idx);
    int unsigned r;
    r = mdl_rank[idx];
    for (int i = 0; i < Depth; i++)
      if (mdl_valid[i] && i != idx && mdl_rank[i] < r) mdl_rank[i]++;
    mdl_rank[idx] = 0;
  endfunction

  function automatic void evict_lru();
    int old;
    old = -1;
    for (int i = 0; i < Depth; i++)
      if (mdl_valid[i] && (old < 0 || mdl_rank[i] > mdl_rank[old])) old = i;
    if (old >= 0) drop_slot(old);
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < Depth; i++)
      if (!mdl_valid[i]) return i;
    return -1;
  endfunction

  function automatic lookup_result_t cache_predict(logic [2:0] cmd, logic [63:0] k,
                                                   logic [63:0] v, logic ttl,
                                                   logic [15:0] secs);
    lookup_result_t res;
    int idx;
    int unsigned cap;
    res = '0;
    cap = (mdl_capacity < 1) ? 1 : ((mdl_capacity > Depth) ? Depth : mdl_capacity);
    case (cmd)
      lkvc_pkg::CMD_GET, lkvc_pkg::CMD_EXISTS: begin
        idx = find_slot(k);
        if (idx >= 0) begin
          if (mdl_ttl[idx] && mdl_now >= mdl_expiry[idx]) begin
            drop_slot(idx);
          end else begin
            res.found = 1'b1;
            if (cmd == lkvc_pkg::CMD_GET) begin
              res.read_value = mdl_value[idx];
              touch_slot(idx);
            end
          end
        end
      end
      lkvc_pkg::CMD_SET: begin
        idx = find_slot(k);
        if (idx >= 0) begin
          res.found = 1'b1;
        end else begin
          if (mdl_live >= cap) evict_lru();
          idx = free_slot();
          if (idx < 0) begin
            evict_lru();
            idx = free_slot();
          end
          if (idx < 0) idx = 0;
          mdl_valid[idx] = 1'b1;
          mdl_key[idx] = k;
          mdl_rank[idx] = mdl_live;
          mdl_live++;
        end
        mdl_value[idx] = v;
        mdl_ttl[idx] = ttl;
        if (ttl) mdl_expiry[idx] = (mdl_now + secs) & TimeMask;
        touch_slot(idx);
      end
      lkvc_pkg::CMD_REMOVE: begin
        idx = find_slot(k);
        if (idx >= 0) begin
          drop_slot(idx);
          res.found = 1'b1;
        end
      end
      lkvc_pkg::CMD_TICK: mdl_now = (mdl_now + 1) & TimeMask;
      default: ;
    endcase
    return res;
  endfunction

  // sends one command request, predicts its result on acceptance
  // tvalid stays high after acceptance until the next request or a drain
  task automatic send_request(logic [2:0] cmd, logic [63:0] k, logic [63:0] v,
                              logic ttl, logic [15:0] secs);
    while (!quiet_mode && $urandom_range(99) < 18) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {7'd0, secs, ttl, v, k};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(cache_predict(cmd, k, v, ttl, secs));
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 10) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mdl_capacity = cap;
  endtask

  // receiver stalls at random; checks each result against the oldest prediction
  always @(posedge clk_i) begin
    lookup_result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result found=%0b value=%h",
                                          m_axis_tuser_o, m_axis_tdata_o);
        end else begin
          exp_res = pending_results.pop_front();
          if (exp_res.found !== m_axis_tuser_o || exp_res.read_value !== m_axis_tdata_o) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: expected found=%0b value=%h, got found=%0b value=%h",
                       exp_res.found, exp_res.read_value, m_axis_tuser_o, m_axis_tdata_o);
          end
        end
      end
      m_axis_tready_i <= quiet_mode || ($urandom_range(99) >= 18);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // extremes of every field and each command, including the unused codes
  task automatic test_directed();
    send_request(lkvc_pkg::CMD_GET, 64'd0, 64'd0, 1'b0, 16'd0);
    send_request(lkvc_pkg::CMD_SET, 64'd0, '1, 1'b0, '1);
    send_request(lkvc_pkg::CMD_SET, '1, 64'd0, 1'b1, '1);
    send_request(lkvc_pkg::CMD_GET, 64'd0, 64'd0, 1'b0, 16'd0);
    send_request(lkvc_pkg::CMD_EXISTS, '1, '1, 1'b1, '1);
    // zero ttl expires at once
    send_request(lkvc_pkg::CMD_SET, 64'h5a5a, 64'h1234, 1'b1, 16'd0);
    send_request(lkvc_pkg::CMD_EXISTS, 64'h5a5a, 64'd0, 1'b0, 16'd0);
    send_request(lkvc_pkg::CMD_SET, 64'h77, 64'h99, 1'b1, 16'd1);
    send_request(lkvc_pkg::CMD_SET, 64'h77, 64'h98, 1'b0, 16'd0);  // clears the ttl flag
    send_request(lkvc_pkg::CMD_TICK, 64'd0, 64'd0, 1'b0, 16'd0);
    send_request(lkvc_pkg::CMD_GET, 64'h77, 64'd0, 1'b0, 16'd0);
    send_request(lkvc_pkg::CMD_SET, 64'h88, 64'h1, 1'b1, 16'd1);
    send_request(lkvc_pkg::CMD_TICK, '1, '1, 1'b1, '1);
    send_request(lkvc_pkg::CMD_SET, 64'h88, 64'h2, 1'b1, 16'd3);   // set on an expired entry
    send_request(lkvc_pkg::CMD_GET, 64'h88, 64'd0, 1'b0, 16'd0);
    send_request(lkvc_pkg::CMD_REMOVE, 64'h88, 64'd0, 1'b0, 16'd0);
    send_request(lkvc_pkg::CMD_REMOVE, 64'h88, 64'd0, 1'b0, 16'd0);
    for (int c = 5; c < 8; c++) send_request(c[2:0], '1, '1, 1'b1, '1);
  endtask

  // random traffic over a small key pool so that hits, evictions and expiry all occur
  task automatic test_random(int count, int unsigned pool);
    logic [2:0] cmd;
    logic [63:0] k;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) cmd = lkvc_pkg::CMD_SET;
      else if (pick < 60) cmd = lkvc_pkg::CMD_GET;
      else if (pick < 72) cmd = lkvc_pkg::CMD_EXISTS;
      else if (pick < 82) cmd = lkvc_pkg::CMD_REMOVE;
      else if (pick < 97) cmd = lkvc_pkg::CMD_TICK;
      else cmd = 3'($urandom_range(7, 5));
      k = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(pool - 1)) ^ 64'hf0f0_0000_0000;
      send_request(cmd, k, rand64(), 1'($urandom()), ($urandom_range(3) == 0) ?
                   16'($urandom()) : 16'($urandom_range(6)));
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      mdl_valid[i] = 1'b0; mdl_key[i] = '0; mdl_value[i] = '0;
      mdl_ttl[i] = 1'b0; mdl_expiry[i] = '0; mdl_rank[i] = 0;
    end
    mdl_live = 0;
    mdl_now = '0;
    mdl_capacity = lkvc_pkg::CapReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200, 90);
    write_capacity(7'd1);
    test_random(80, 6);
    write_capacity(7'd0);
    test_random(60, 4);
    write_capacity(7'd4);
    test_random(120, 12);
    write_capacity(7'd127);
    quiet_mode = 1'b1;
    test_random(120, 100);
    quiet_mode = 1'b0;
    write_capacity(7'd64);
    test_random(220, 80);
    drain_results();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
